// ----- rtl/dntw_pkg.sv -----
// shared types, constants and helpers for the dns name text to wire unit
`timescale 1ns / 1ps
`default_nettype none
package dntw_pkg;

	localparam int LEN_W = 6;
	localparam int STORE_DEPTH = 64;
	localparam int RAM_DEPTH = 2 * STORE_DEPTH;
	localparam int RAM_AW = 7;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_DOT = 8'h2e;

	// one queued job for the back end: flush a label or report an overflow
	typedef struct packed {
		logic err;
		logic eon;
		logic bank;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// back end hands a label bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic is_delim(input logic [7:0] c);
		logic d;
		d = 1'b0;
		case (c) inside
			CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE,
			CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_SEMI: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/dntw_ram.sv -----
// generic single write, single registered read ram
`timescale 1ns / 1ps
`default_nettype none
module dntw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dntw_front.sv -----
// front end: classifies characters, buffers label bytes, queues flush jobs
`timescale 1ns / 1ps
`default_nettype none
module dntw_front
	import dntw_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        char_byte,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   ram_wr_en,
	output logic      [RAM_AW-1:0] ram_wr_addr,
	output logic      [7:0]        ram_wr_data,
	output logic                   cmd_push,
	output cmd_t                   cmd,
	input  wire logic              cmd_full,
	input  wire rel_t              rel
);

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_LABEL);

	logic [LEN_W-1:0] len_q;
	logic             skip_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_set, busy_clr;
	logic             acc, delim, dot, over, flush;

	assign in_ready = !cmd_full && !busy_q[bank_q];
	assign acc = in_valid && in_ready;
	assign delim = is_delim(char_byte);
	assign dot = (char_byte == CH_DOT);
	assign flush = acc && !skip_q && (delim || dot);
	assign over = acc && !skip_q && !delim && !dot && (len_q >= MaxLen);

	assign ram_wr_en = acc && !skip_q && !delim && !dot && (len_q < MaxLen);
	assign ram_wr_addr = {bank_q, len_q};
	assign ram_wr_data = char_byte;

	// released bank is never the one being filled, so set and clear never collide
	assign busy_clr = rel.valid ? (2'b01 << rel.bank) : 2'b00;
	assign busy_set = (flush && (len_q != '0)) ? (2'b01 << bank_q) : 2'b00;

	assign cmd_push = flush || over;
	always_comb begin
		cmd.err = over;
		cmd.eon = delim && !over;
		cmd.bank = bank_q;
		cmd.len = over ? '0 : len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			skip_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (acc) begin
				if (skip_q) begin
					if (delim) begin
						skip_q <= 1'b0;
						len_q <= '0;
					end
				end else if (flush) begin
					// an empty label carries no bytes, so its bank stays put
					if (len_q != '0) begin
						bank_q <= !bank_q;
					end
					len_q <= '0;
				end else if (over) begin
					len_q <= '0;
					skip_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dntw_cmd_fifo.sv -----
// small queue of flush jobs between front and back end
`timescale 1ns / 1ps
`default_nettype none
module dntw_cmd_fifo
	import dntw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      pop_data,
	output logic      empty
);

	cmd_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + (FIFO_AW+1)'(1);
				2'b01: cnt_q <= cnt_q - (FIFO_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dntw_back.sv -----
// back end: emits the length byte (a zero byte for an overflow report), then streams label bytes from the buffer
`timescale 1ns / 1ps
`default_nettype none
module dntw_back
	import dntw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	output logic                   ram_rd_en,
	output logic      [RAM_AW-1:0] ram_rd_addr,
	input  wire logic [7:0]        ram_rd_data,
	output rel_t                   rel,
	output logic      [7:0]        wire_byte,
	output logic                   last,
	output logic                   end_of_name,
	output logic                   error,
	output logic                   out_valid,
	input  wire logic              out_ready
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DATA = 2'b10
	} state_t;

	state_t           state_q;
	logic             bank_q, eon_q;
	logic [LEN_W-1:0] len_q, idx_q;
	logic             pend_q, pend_last_q, pend_eon_q;
	logic             out_free, move, issue, final_rd;

	assign out_free = !out_valid || out_ready;
	assign move = pend_q && out_free;
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty && !pend_q && out_free;
	// a read may go out when the data register will be free next cycle
	assign issue = (state_q == ST_DATA) && (!pend_q || move);
	assign final_rd = (idx_q == len_q - LEN_W'(1));

	assign ram_rd_en = issue;
	assign ram_rd_addr = {bank_q, idx_q};
	assign rel.valid = issue && final_rd;
	assign rel.bank = bank_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			wire_byte <= cmd.err ? 8'h00 : {{(8 - LEN_W){1'b0}}, cmd.len};
			last <= cmd.err || (cmd.len == '0);
			end_of_name <= cmd.eon;
			error <= cmd.err;
		end else if (move) begin
			wire_byte <= ram_rd_data;
			last <= pend_last_q;
			end_of_name <= pend_eon_q;
			error <= 1'b0;
		end
		if (cmd_pop) begin
			bank_q <= cmd.bank;
			len_q <= cmd.len;
			eon_q <= cmd.eon;
		end
		if (issue) begin
			pend_last_q <= final_rd;
			pend_eon_q <= eon_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd_pop || move) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && !cmd.err && (cmd.len != '0)) begin
						idx_q <= '0;
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (issue) begin
						idx_q <= idx_q + LEN_W'(1);
						if (final_rd) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dns_name_text_to_wire_unit.sv -----
// top level: dns name text to wire form converter
// flow: once its dot is taken, a label's length byte is queued as a job and then registered at the output
// throughput: one character per cycle in while in_ready is high; out, the output sits idle after
// each nonzero length byte while the first byte of that label is read from the buffer
// input stalls only when both banks wait to drain or the 4-entry job queue is full
// reset: arst_n clears control state at once; buffer ram contents stay undefined
`timescale 1ns / 1ps
`default_nettype none
module dns_name_text_to_wire_unit
	import dntw_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] char_byte,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic      [7:0] wire_byte,
	output logic            last,
	output logic            end_of_name,
	output logic            error,
	output logic            out_valid,
	input  wire logic       out_ready
);

	logic              wr_en, rd_en, push, pop, full, empty;
	logic [RAM_AW-1:0] wr_addr, rd_addr;
	logic [7:0]        wr_data, rd_data;
	cmd_t              cmd_in, cmd_out;
	rel_t              rel;

	dntw_front #(
		.MAX_LABEL(MAX_LABEL)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_byte(char_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ram_wr_en(wr_en),
		.ram_wr_addr(wr_addr),
		.ram_wr_data(wr_data),
		.cmd_push(push),
		.cmd(cmd_in),
		.cmd_full(full),
		.rel(rel)
	);

	dntw_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(cmd_in),
		.full(full),
		.pop(pop),
		.pop_data(cmd_out),
		.empty(empty)
	);

	dntw_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dntw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(empty),
		.cmd_pop(pop),
		.ram_rd_en(rd_en),
		.ram_rd_addr(rd_addr),
		.ram_rd_data(rd_data),
		.rel(rel),
		.wire_byte(wire_byte),
		.last(last),
		.end_of_name(end_of_name),
		.error(error),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

endmodule
`default_nettype wire

// ----- rtl/dntw_checker.sv -----
// port-level checker for the dns name text to wire unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dntw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic [7:0] wire_byte,
	input wire logic       last,
	input wire logic       end_of_name,
	input wire logic       error,
	input wire logic       out_valid,
	input wire logic       out_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wire_byte) && $stable(last))
		else $error("stalled result changed");

	// an overflow report is a lone item with no payload
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && !end_of_name && (wire_byte == 8'h00))
		else $error("malformed error item");

	// an error item never cuts into a stalled label
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !$past(out_valid && !out_ready && !last))
		else $error("error item interrupted a label");

	// no result while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result during reset");

endmodule

bind dns_name_text_to_wire_unit dntw_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.wire_byte(wire_byte),
	.last(last),
	.end_of_name(end_of_name),
	.error(error),
	.out_valid(out_valid),
	.out_ready(out_ready)
);
`default_nettype wire

// ----- test/tb_dns_name_text_to_wire_unit.sv -----
// testbench for the dns name text to wire unit: directed names, overflow, pressure, random
`timescale 1ns / 1ps
module tb_dns_name_text_to_wire_unit
	import dntw_pkg::*;
();

	localparam int MAX_LABEL_LEN = 63;
	localparam int RANDOM_ITEMS = 45;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct {
		logic [7:0] wire_byte;
		logic       last;
		logic       eon;
		logic       err;
	} wire_result_t;

	logic       clk;
	logic       arst_n;
	logic [7:0] char_byte;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] wire_byte;
	logic       last;
	logic       end_of_name;
	logic       error;
	logic       out_valid;
	logic       out_ready;

	// predictor state
	logic [7:0] label_buf [0:63];
	logic [6:0] label_len;
	logic       dropping;
	wire_result_t pending_wire [$];
	wire_result_t exp_res;

	// sender and receiver control
	bit       gaps_on;
	int       burst_left;
	rx_mode_t rx_mode;
	bit       rx_hold_req;
	int       hold_left;
	int       rx_phase;

	// bookkeeping
	int fail_count;
	int item_count;
	int dropped_count;
	int name_count;
	int overflow_count;
	int results_checked;
	int idle_cycles;

	dns_name_text_to_wire_unit #(
		.MAX_LABEL(MAX_LABEL_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_byte(char_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.wire_byte(wire_byte),
		.last(last),
		.end_of_name(end_of_name),
		.error(error),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit is_text_delim(input logic [7:0] c);
		case (c)
			CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE,
			CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_SEMI: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(0, 8))
			0: return CH_NUL;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_CR;
			4: return CH_SPACE;
			5: return CH_QUOTE;
			6: return CH_LPAREN;
			7: return CH_RPAREN;
			default: return CH_SEMI;
		endcase
	endfunction

	function automatic logic [7:0] rand_plain_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (is_text_delim(c) || c == CH_DOT);
		return c;
	endfunction

	task automatic push_wire(input logic [7:0] b, input logic l, input logic eon,
			input logic err);
		wire_result_t r;
		r.wire_byte = b;
		r.last = l;
		r.eon = eon;
		r.err = err;
		pending_wire.push_back(r);
	endtask

	// buffered label goes out as a length byte and then its characters
	task automatic flush_label_bytes(input logic eon);
		int n;
		n = int'(label_len);
		push_wire(8'(n), n == 0, eon, 1'b0);
		for (int i = 0; i < n; i++)
			push_wire(label_buf[i], i + 1 == n, eon, 1'b0);
		label_len = '0;
	endtask

	task automatic encode_wire_char(input logic [7:0] c);
		if (dropping) begin
			dropped_count++;
			if (is_text_delim(c)) begin
				dropping = 1'b0;
				label_len = '0;
				name_count++;
			end
		end else begin
			item_count++;
			if (is_text_delim(c)) begin
				flush_label_bytes(1'b1);
				name_count++;
			end else if (c == CH_DOT) begin
				flush_label_bytes(1'b0);
			end else if (int'(label_len) >= MAX_LABEL_LEN) begin
				label_len = '0;
				dropping = 1'b1;
				overflow_count++;
				push_wire(8'h00, 1'b1, 1'b0, 1'b1);
			end else begin
				label_buf[label_len[5:0]] = c;
				label_len = label_len + 7'd1;
			end
		end
	endtask

	task automatic send_char(input logic [7:0] c);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		char_byte <= c;
		do @(posedge clk); while (!in_ready);
		encode_wire_char(c);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_label(input int n);
		repeat (n) send_char(rand_plain_char());
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		fail_count++;
		$error("%s mismatch: expected %0h, got %0h", field, want, got);
	endtask

	// receiver: own stall pattern plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		rx_phase = 0;
		forever begin
			@(negedge clk);
			rx_phase++;
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
					default: out_ready <= ((rx_phase % 7) < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_wire.size() == 0) begin
				fail_count++;
				$error("unexpected result: wire_byte %0h error %0b", wire_byte, error);
			end else begin
				exp_res = pending_wire.pop_front();
				results_checked++;
				if (wire_byte !== exp_res.wire_byte)
					report_mismatch("wire_byte", exp_res.wire_byte, wire_byte);
				if (last !== exp_res.last)
					report_mismatch("last", exp_res.last, last);
				if (end_of_name !== exp_res.eon)
					report_mismatch("end_of_name", exp_res.eon, end_of_name);
				if (error !== exp_res.err)
					report_mismatch("error", exp_res.err, error);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed_names();
		rx_mode = RX_ALWAYS;
		gaps_on = 1'b0;
		send_text("ab.c");
		send_char(CH_SPACE);
		send_text("x.");
		send_char(CH_NUL);
		// name that starts at a delimiter
		send_char(CH_SEMI);
		send_text("a..b");
		send_char(CH_TAB);
		rx_mode = RX_PATTERN;
		send_char(8'hff);
		send_char(8'h80);
		send_char(8'h01);
		send_char(8'h7f);
		send_char(CH_LF);
		send_char(CH_DOT);
		send_char(CH_CR);
		send_char(8'h7a);
		send_char(CH_QUOTE);
		send_char(CH_LPAREN);
		send_char(CH_RPAREN);
	endtask

	task automatic test_label_limits();
		rx_mode = RX_RANDOM;
		gaps_on = 1'b1;
		send_label(MAX_LABEL_LEN);
		send_char(CH_DOT);
		send_label(1);
		send_char(CH_SPACE);
		// one char too many, then dots and text are dropped up to the delimiter
		send_label(MAX_LABEL_LEN + 1);
		send_text("a.b.");
		send_char(8'hfe);
		send_char(CH_RPAREN);
		send_text("ok");
		send_char(CH_NUL);
	endtask

	task automatic test_output_pressure();
		rx_mode = RX_ALWAYS;
		gaps_on = 1'b0;
		rx_hold_req = 1'b1;
		repeat (2) begin
			repeat (2) begin
				send_label($urandom_range(4, 8));
				send_char(CH_DOT);
			end
			send_char(pick_delim());
		end
	endtask

	task automatic test_random_names();
		int start_count;
		int n_labels;
		int r;
		int len;
		start_count = item_count;
		while (item_count - start_count < RANDOM_ITEMS) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 12) begin
				// noise: arbitrary bytes, dots weighted up
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) == 0)
						send_char(CH_DOT);
					else
						send_char(8'($urandom_range(0, 255)));
				end
			end else begin
				n_labels = $urandom_range(1, 4);
				for (int k = 0; k < n_labels; k++) begin
					r = $urandom_range(0, 99);
					if (r < 5)
						len = 0;
					else if (r < 93)
						len = $urandom_range(1, 10);
					else if (r < 97)
						len = $urandom_range(40, MAX_LABEL_LEN);
					else
						len = $urandom_range(MAX_LABEL_LEN + 1, MAX_LABEL_LEN + 3);
					send_label(len);
					if (k + 1 < n_labels || $urandom_range(0, 3) == 0)
						send_char(CH_DOT);
				end
				send_char(pick_delim());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_byte = 8'h00;
		rx_mode = RX_ALWAYS;
		rx_hold_req = 1'b0;
		gaps_on = 1'b0;
		burst_left = 0;
		label_len = '0;
		dropping = 1'b0;
		fail_count = 0;
		item_count = 0;
		dropped_count = 0;
		name_count = 0;
		overflow_count = 0;
		results_checked = 0;
		idle_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_names();
		test_label_limits();
		test_output_pressure();
		test_random_names();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_wire.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d characters and %0d dropped after overflow, %0d wire bytes checked",
			item_count, dropped_count, results_checked);
		$display("%0d names ended, %0d label overflows, one long output hold-off",
			name_count, overflow_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
